// ----- rtl/ircar_pkg.sv -----
// shared types and constants for the ir cliff average and range block
`default_nettype none

package ircar_pkg;

	localparam int DIV_NW = 24;
	localparam int DIV_DW = 13;

	localparam logic CFG_CLIFF_THRESHOLD = 1'b0;
	localparam logic CFG_FULL_SCALE      = 1'b1;

	localparam logic [11:0] THRESHOLD_RESET  = 12'd400;
	localparam logic [11:0] FULL_SCALE_RESET = 12'd2600;

	localparam logic [DIV_DW-1:0] MV_DIVISOR  = 13'd4095;
	localparam logic [DIV_DW-1:0] DIST_OFFSET = 13'd50;
	localparam logic [DIV_NW-1:0] DIST_NUM    = 24'd1200000;
	localparam logic [11:0] MV_LOW    = 12'd250;
	localparam logic [11:0] MV_HIGH   = 12'd2500;
	localparam logic [11:0] DIST_BIAS = 12'd42;
	localparam logic [11:0] DIST_MIN  = 12'd100;
	localparam logic [11:0] DIST_MAX  = 12'd2000;
	localparam logic [11:0] DIST_NONE = 12'hFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_MUL,
		ST_MV_SCALE,
		ST_DIST_START,
		ST_DIST_WAIT
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ir_cliff_average_and_range.sv -----
// ir cliff sensor burst averager with millivolt scaling and distance estimate
//
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | tuser: channel; tdata: read_ok, raw_code, scan_start
// m        | out | m_tvalid/m_tready  | tuser: channel_index; tdata: result fields
// cfg      | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// an item that does not end a burst is accumulated without starting the divider
// the item that ends a burst runs two divisions on the shared divider
// (average, distance) with the millivolt scaling between them; the result is loaded
// after the distance division, or without any division for a burst with no good sample
// s_tready is low while that sequence runs and while a result waits for the output register
// reset clears configuration to defaults, accumulators, masks and the output valid
`default_nettype none

module ir_cliff_average_and_range import ircar_pkg::*; #(
	parameter int SAMPLES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic        s_tuser,   // channel
	input  wire logic [15:0] s_tdata,   // read_ok, raw_code, scan_start, zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic             m_tuser,   // channel_index
	output logic [31:0]      m_tdata,   // channel_ok, millivolts, distance_tenth_mm,
	                                    // cliff_here, cliff_any, ok_bits, zero fill
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int SUM_W = $clog2(SAMPLES) + 12;
	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int POS_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

	seq_state_t state_q, state_d;

	logic [11:0]      thr_q;
	logic [11:0]      fs_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] good_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       ok_mask_q;
	logic             cliff_q;
	logic             chan_q;
	logic             ok_q;
	logic [11:0]      avg_q;
	logic [23:0]      prod_q;
	logic [11:0]      mv_q;
	logic [11:0]      dq_q;
	logic             pend_q;

	logic             m_tvalid_q;
	logic             m_tuser_q;
	logic [31:0]      m_tdata_q;

	logic             read_ok;
	logic [11:0]      raw_code;
	logic             scan_start;
	logic             s_acc;
	logic             last_item;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] good_next;
	logic             out_load;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [12:0] mv_fold;
	logic [11:0] mv_scaled;

	logic [11:0] mv_out;
	logic [11:0] dist_out;
	logic        here;
	logic [1:0]  ok_mask_new;
	logic        cliff_new;

	assign read_ok    = s_tdata[0];
	assign raw_code   = s_tdata[12:1];
	assign scan_start = s_tdata[13];

	assign s_acc     = s_tvalid && s_tready;
	assign last_item = pos_q == POS_W'(SAMPLES - 1);
	assign sum_next  = read_ok ? sum_q + SUM_W'(raw_code) : sum_q;
	assign good_next = read_ok ? good_q + 1'b1 : good_q;

	// divide by 4095: high half plus one when high and low halves reach 4095
	assign mv_fold   = {1'b0, prod_q[23:12]} + {1'b0, prod_q[11:0]};
	assign mv_scaled = prod_q[23:12] + 12'(mv_fold >= MV_DIVISOR);

	ircar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && last_item && (good_next != '0)) begin
					state_d = ST_AVG_START;
				end
			end
			ST_AVG_START:  state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:        state_d = ST_MV_SCALE;
			ST_MV_SCALE:   state_d = ST_DIST_START;
			ST_DIST_START: state_d = ST_DIST_WAIT;
			ST_DIST_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_AVG_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = {{(DIV_NW - SUM_W){1'b0}}, sum_q};
				div_req.divisor  = {{(DIV_DW - CNT_W){1'b0}}, good_q};
			end
			ST_DIST_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIST_NUM;
				div_req.divisor  = {1'b0, mv_q} + DIST_OFFSET;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE) && !pend_q;
	assign out_load = pend_q && (!m_tvalid_q || m_tready);

	// result fields
	always_comb begin
		mv_out   = ok_q ? mv_q : 12'd0;
		here     = ok_q && (mv_q < thr_q);
		dist_out = DIST_NONE;
		if (ok_q && (mv_q >= MV_LOW)) begin
			if (mv_q > MV_HIGH) begin
				dist_out = DIST_MIN;
			end else if (dq_q < DIST_MIN + DIST_BIAS) begin
				dist_out = DIST_MIN;
			end else if (dq_q - DIST_BIAS > DIST_MAX) begin
				dist_out = DIST_NONE;
			end else begin
				dist_out = dq_q - DIST_BIAS;
			end
		end
		ok_mask_new = ok_q ? (ok_mask_q | (chan_q ? 2'b10 : 2'b01)) : ok_mask_q;
		cliff_new   = cliff_q | here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			thr_q      <= THRESHOLD_RESET;
			fs_q       <= FULL_SCALE_RESET;
			sum_q      <= '0;
			good_q     <= '0;
			pos_q      <= '0;
			ok_mask_q  <= '0;
			cliff_q    <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLIFF_THRESHOLD: thr_q <= cfg_data;
					CFG_FULL_SCALE:      fs_q  <= cfg_data;
					default:             thr_q <= thr_q;
				endcase
			end
			if (s_acc) begin
				if (scan_start) begin
					ok_mask_q <= '0;
					cliff_q   <= 1'b0;
				end
				sum_q  <= sum_next;
				good_q <= good_next;
				pos_q  <= last_item ? '0 : pos_q + 1'b1;
				if (last_item && (good_next == '0)) begin
					pend_q <= 1'b1;
				end
			end
			if (state_q == ST_AVG_START) begin
				sum_q  <= '0;
				good_q <= '0;
			end
			if ((state_q == ST_DIST_WAIT) && div_rsp.done) begin
				pend_q <= 1'b1;
			end
			if (out_load) begin
				pend_q     <= 1'b0;
				ok_mask_q  <= ok_mask_new;
				cliff_q    <= cliff_new;
				sum_q      <= '0;
				good_q     <= '0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && last_item) begin
			chan_q <= s_tuser;
			ok_q   <= good_next != '0;
		end
		if ((state_q == ST_AVG_WAIT) && div_rsp.done) begin
			avg_q <= div_rsp.quotient[11:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= 24'(fs_q) * 24'(avg_q);
		end
		if (state_q == ST_MV_SCALE) begin
			mv_q <= mv_scaled;
		end
		if ((state_q == ST_DIST_WAIT) && div_rsp.done) begin
			dq_q <= div_rsp.quotient[11:0];
		end
		if (out_load) begin
			m_tuser_q <= chan_q;
			m_tdata_q <= {3'b000, ok_mask_new, cliff_new, here, dist_out, mv_out, ok_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(SAMPLES - 1))
		else $error("burst position out of range");

	a_empty_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> ((m_tdata[12:1] == 12'd0) &&
		(m_tdata[24:13] == DIST_NONE) && !m_tdata[25]))
		else $error("empty burst result carries values");

	a_ok_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tuser ? m_tdata[28] : m_tdata[27]))
		else $error("ok mask misses the result channel");

endmodule

`default_nettype wire

// ----- rtl/ircar_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module ircar_div import ircar_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] div_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, div_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire
